FILE: design/pf_pkg.sv
package pf_pkg;

  localparam int LETTERS  = 26;
  localparam int SQ_CELLS = 25;

  typedef logic [4:0] letter_t;
  typedef logic [2:0] rc_t;
  typedef logic [3:0] step_t;
  typedef logic [1:0] req_t;

  localparam letter_t LET_I      = 5'd8;
  localparam letter_t LET_J      = 5'd9;
  localparam letter_t LET_Z      = 5'd25;
  localparam letter_t PAD_RESET  = 5'd23;
  localparam letter_t FILL_LAST  = 5'd25;
  localparam letter_t CELLS_FULL = 5'd25;

  localparam req_t REQ_START  = 2'd0;
  localparam req_t REQ_KEY    = 2'd1;
  localparam req_t REQ_FINISH = 2'd2;
  localparam req_t REQ_MSG    = 2'd3;

  localparam logic REG_MODE = 1'b0;
  localparam logic REG_PAD  = 1'b1;

  localparam step_t STEP_IDLE     = 4'd0;
  localparam step_t STEP_CLEAR    = 4'd1;
  localparam step_t STEP_KEY      = 4'd2;
  localparam step_t STEP_FILL     = 4'd3;
  localparam step_t STEP_MSG      = 4'd4;
  localparam step_t STEP_READ_POS = 4'd5;
  localparam step_t STEP_READ_SQ  = 4'd6;
  localparam step_t STEP_EMIT_X   = 4'd7;
  localparam step_t STEP_EMIT_Y   = 4'd8;
  localparam step_t STEP_AGAIN    = 4'd9;

  typedef enum logic [3:0] {
    OP_NOP        = 4'd0,
    OP_CLEAR      = 4'd1,
    OP_PLACE_KEY  = 4'd2,
    OP_PLACE_FILL = 4'd3,
    OP_MSG        = 4'd4,
    OP_READ_POS   = 4'd5,
    OP_READ_SQ    = 4'd6,
    OP_EMIT_X     = 4'd7,
    OP_EMIT_Y     = 4'd8,
    OP_AGAIN      = 4'd9
  } dp_op_t;

  typedef enum logic [2:0] {
    J_ALWAYS    = 3'd0,
    J_DISPATCH  = 3'd1,
    J_FILL_DONE = 3'd2,
    J_PAIR      = 3'd3,
    J_OUT_FREE  = 3'd4,
    J_MORE      = 3'd5
  } jcond_t;

  typedef struct packed {
    dp_op_t op;
    jcond_t cond;
    step_t  tgt;
    step_t  alt;
  } ucode_t;

  typedef struct packed {
    dp_op_t op;
    logic   accept;
  } dp_ctrl_t;

  typedef struct packed {
    logic pair_needed;
    logic more;
    logic fill_done;
    logic out_free;
  } dp_status_t;

  function automatic ucode_t ucode_rom(step_t s);
    ucode_t w;
    unique case (s)
      STEP_IDLE:     w = '{OP_NOP,        J_DISPATCH,  STEP_IDLE,     STEP_IDLE};
      STEP_CLEAR:    w = '{OP_CLEAR,      J_ALWAYS,    STEP_IDLE,     STEP_IDLE};
      STEP_KEY:      w = '{OP_PLACE_KEY,  J_ALWAYS,    STEP_IDLE,     STEP_IDLE};
      STEP_FILL:     w = '{OP_PLACE_FILL, J_FILL_DONE, STEP_IDLE,     STEP_FILL};
      STEP_MSG:      w = '{OP_MSG,        J_PAIR,      STEP_READ_POS, STEP_IDLE};
      STEP_READ_POS: w = '{OP_READ_POS,   J_ALWAYS,    STEP_READ_SQ,  STEP_READ_SQ};
      STEP_READ_SQ:  w = '{OP_READ_SQ,    J_ALWAYS,    STEP_EMIT_X,   STEP_EMIT_X};
      STEP_EMIT_X:   w = '{OP_EMIT_X,     J_OUT_FREE,  STEP_EMIT_Y,   STEP_EMIT_X};
      STEP_EMIT_Y:   w = '{OP_EMIT_Y,     J_OUT_FREE,  STEP_AGAIN,    STEP_EMIT_Y};
      STEP_AGAIN:    w = '{OP_AGAIN,      J_MORE,      STEP_EMIT_X,   STEP_IDLE};
      default:       w = '{OP_NOP,        J_ALWAYS,    STEP_IDLE,     STEP_IDLE};
    endcase
    return w;
  endfunction

  function automatic letter_t norm_letter(letter_t v);
    letter_t r;
    if (v > LET_Z) begin
      r = LET_Z;
    end else if (v == LET_J) begin
      r = LET_I;
    end else begin
      r = v;
    end
    return r;
  endfunction

  // Row of a square position: p * 13 / 64 equals p / 5 for every position below 25.
  function automatic rc_t pos_row(letter_t p);
    logic [9:0] prod;
    prod = {5'b0, p} * 10'd13;
    return prod[8:6];
  endfunction

  function automatic rc_t pos_col(letter_t p, rc_t row);
    letter_t c;
    c = p - ({2'b0, row} << 2) - {2'b0, row};
    return c[2:0];
  endfunction

  function automatic rc_t shift5(rc_t c, logic fwd);
    rc_t r;
    if (fwd) begin
      r = (c == 3'd4) ? 3'd0 : c + 3'd1;
    end else begin
      r = (c == 3'd0) ? 3'd4 : c - 3'd1;
    end
    return r;
  endfunction

  function automatic letter_t sq_addr(rc_t row, rc_t col);
    return ({2'b0, row} << 2) + {2'b0, row} + {2'b0, col};
  endfunction

endpackage

FILE: design/pf_seq.sv
module pf_seq (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  pf_pkg::req_t        in_req,
  input  pf_pkg::dp_status_t  status,
  output logic                in_ready,
  output pf_pkg::dp_ctrl_t    ctrl
);
  import pf_pkg::*;

  step_t  pc;
  step_t  pc_next;
  ucode_t word;
  logic   cond_true;

  assign word     = ucode_rom(pc);
  assign in_ready = (pc == STEP_IDLE);

  always_comb begin
    case (word.cond)
      J_ALWAYS:    cond_true = 1'b1;
      J_FILL_DONE: cond_true = status.fill_done;
      J_PAIR:      cond_true = status.pair_needed;
      J_OUT_FREE:  cond_true = status.out_free;
      J_MORE:      cond_true = status.more;
      default:     cond_true = 1'b0;
    endcase
  end

  always_comb begin
    if (word.cond == J_DISPATCH) begin
      pc_next = (in_valid && in_ready) ? STEP_CLEAR + {2'b0, in_req} : pc;
    end else begin
      pc_next = cond_true ? word.tgt : word.alt;
    end
  end

  assign ctrl.op     = word.op;
  assign ctrl.accept = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= STEP_IDLE;
    end else begin
      pc <= pc_next;
    end
  end

endmodule

FILE: design/pf_datapath.sv
module pf_datapath (
  input  logic                clk,
  input  logic                rst,
  input  pf_pkg::dp_ctrl_t    ctrl,
  input  pf_pkg::letter_t     in_letter,
  input  logic                in_last,
  input  logic                encrypt_mode,
  input  pf_pkg::letter_t     pad_letter,
  input  logic                out_ready,
  output pf_pkg::dp_status_t  status,
  output logic                out_valid,
  output pf_pkg::letter_t     out_letter,
  output logic                out_last
);
  import pf_pkg::*;

  letter_t sq_mem  [SQ_CELLS];
  letter_t pos_mem [LETTERS];
  logic [LETTERS-1:0] used;

  letter_t fill_count;
  letter_t cnt;
  letter_t item_letter;
  logic    item_last;
  letter_t held_letter;
  logic    held_valid;
  letter_t op_a;
  letter_t op_b;
  logic    more;
  letter_t pa;
  letter_t pb;
  letter_t sx;
  letter_t sy;

  letter_t place_src;
  logic    place_en;
  logic    used_hit;
  letter_t msg_l;
  letter_t msg_pad;
  rc_t     ra, ca, rb, cb;
  letter_t xa, ya;
  logic    out_free;

  assign out_free = !out_valid || out_ready;
  assign msg_l    = norm_letter(item_letter);
  assign msg_pad  = norm_letter(pad_letter);

  assign status.pair_needed = held_valid || item_last;
  assign status.more        = more;
  assign status.fill_done   = (cnt == FILL_LAST);
  assign status.out_free    = out_free;

  always_comb begin
    place_src = (ctrl.op == OP_PLACE_FILL) ? cnt : item_letter;
    used_hit  = (place_src < letter_t'(LETTERS)) ? used[place_src] : 1'b1;
    place_en  = ((ctrl.op == OP_PLACE_KEY) || (ctrl.op == OP_PLACE_FILL)) &&
                (place_src != LET_J) && !used_hit && (fill_count < CELLS_FULL);
  end

  always_comb begin
    ra = pos_row(pa);
    rb = pos_row(pb);
    ca = pos_col(pa, ra);
    cb = pos_col(pb, rb);
    if (ra == rb) begin
      xa = sq_addr(ra, shift5(ca, encrypt_mode));
      ya = sq_addr(rb, shift5(cb, encrypt_mode));
    end else if (ca == cb) begin
      xa = sq_addr(shift5(ra, encrypt_mode), ca);
      ya = sq_addr(shift5(rb, encrypt_mode), cb);
    end else begin
      xa = sq_addr(ra, cb);
      ya = sq_addr(rb, ca);
    end
  end

  always_ff @(posedge clk) begin
    if (place_en) begin
      sq_mem[fill_count] <= place_src;
      pos_mem[place_src] <= fill_count;
    end
    if (ctrl.op == OP_READ_POS) begin
      pa <= pos_mem[op_a];
      pb <= pos_mem[op_b];
    end
    if (ctrl.op == OP_READ_SQ) begin
      sx <= sq_mem[xa];
      sy <= sq_mem[ya];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used       <= '0;
      fill_count <= '0;
      held_valid <= 1'b0;
      more       <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (ctrl.accept) begin
        item_letter <= in_letter;
        item_last   <= in_last;
        cnt         <= '0;
      end
      if (ctrl.op == OP_CLEAR) begin
        used       <= '0;
        fill_count <= '0;
        held_valid <= 1'b0;
      end
      if (place_en) begin
        used[place_src] <= 1'b1;
        fill_count      <= fill_count + 5'd1;
      end
      if (ctrl.op == OP_PLACE_FILL) begin
        cnt <= cnt + 5'd1;
      end
      if (ctrl.op == OP_MSG) begin
        if (!held_valid) begin
          if (item_last) begin
            op_a <= msg_l;
            op_b <= msg_pad;
            more <= 1'b0;
          end else begin
            held_letter <= msg_l;
            held_valid  <= 1'b1;
          end
        end else if (held_letter == msg_l) begin
          // A double letter: the repeated letter stays held unless it is the last.
          op_a <= held_letter;
          op_b <= msg_pad;
          more <= item_last;
          if (item_last) begin
            held_valid <= 1'b0;
          end
        end else begin
          op_a       <= held_letter;
          op_b       <= msg_l;
          more       <= 1'b0;
          held_valid <= 1'b0;
        end
      end
      if (ctrl.op == OP_AGAIN) begin
        more <= 1'b0;
      end
      if (((ctrl.op == OP_EMIT_X) || (ctrl.op == OP_EMIT_Y)) && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if ((ctrl.op == OP_EMIT_X) && out_free) begin
        out_letter <= sx;
        out_last   <= 1'b0;
      end
      if ((ctrl.op == OP_EMIT_Y) && out_free) begin
        out_letter <= sy;
        out_last   <= !more;
      end
    end
  end

endmodule

FILE: design/playfair_digraph_cipher.sv
// Channel   Direction  Contents
// s_*       in         tdata[4:0] letter, tuser req_type, tlast message_end
// m_*       out        tdata[4:0] out_letter, tlast run_last
// APB       in/out     0x0 encrypt_mode, 0x4 pad_letter
//
// A start request runs the clear step, a key request the key step, and a finish request places
// one alphabet letter per cycle. A held message letter runs only the message step; a letter that
// completes a pair adds registered table reads and emit steps, and a final double letter a pad pair.
// Reset clears the sequencer, the used flags, the fill count and the held letter; the
// square and the position table are undefined until written and are not swept.
// A stalled output holds the sequencer at its emit step; one result waits in the output register.
module playfair_digraph_cipher (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [4:0] letter
  input  logic [1:0]  s_tuser,   // [1:0] req_type
  input  logic        s_tlast,   // message_end
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // [4:0] out_letter
  output logic        m_tlast,   // run_last
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import pf_pkg::*;

  logic       encrypt_mode;
  letter_t    pad_letter;
  dp_ctrl_t   ctrl;
  dp_status_t status;
  letter_t    out_letter;
  logic       cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == REG_PAD) ? {27'b0, pad_letter} : {31'b0, encrypt_mode};
  assign m_tdata = {3'b0, out_letter};

  always_ff @(posedge clk) begin
    if (rst) begin
      encrypt_mode <= 1'b1;
      pad_letter   <= PAD_RESET;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_MODE) begin
        encrypt_mode <= pwdata[0];
      end else begin
        pad_letter <= pwdata[4:0];
      end
    end
  end

  pf_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_req   (s_tuser),
    .status   (status),
    .in_ready (s_tready),
    .ctrl     (ctrl)
  );

  pf_datapath u_dp (
    .clk          (clk),
    .rst          (rst),
    .ctrl         (ctrl),
    .in_letter    (s_tdata[4:0]),
    .in_last      (s_tlast),
    .encrypt_mode (encrypt_mode),
    .pad_letter   (pad_letter),
    .out_ready    (m_tready),
    .status       (status),
    .out_valid    (m_tvalid),
    .out_letter   (out_letter),
    .out_last     (m_tlast)
  );

  a_busy_after_request: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input taken again in the cycle after a request");

  a_no_instant_result: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && !m_tvalid) |=> !m_tvalid)
    else $error("result appeared in the cycle after a request");

  a_ready_after_reset: assert property (@(posedge clk)
    rst |=> s_tready)
    else $error("input not ready after reset");

endmodule

FILE: dv/playfair_digraph_cipher_tb.sv
module playfair_digraph_cipher_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pf_pkg::*;

  localparam logic [2:0] ADDR_MODE = 3'd0;
  localparam logic [2:0] ADDR_PAD  = 3'd4;
  localparam int DRAIN_CYCLES = 40;

  typedef struct packed {
    letter_t letter;
    logic    last;
  } result_t;

  typedef letter_t [0:3] quad_t;

  typedef struct packed {
    logic       is_cfg;
    logic [2:0] addr;
    req_t       req;
    letter_t    ltr;
    logic       last;
    logic [2:0] nres;
    quad_t      lets;
  } script_row_t;

  localparam int SCRIPT_LEN = 32;
  localparam script_row_t SCRIPT [SCRIPT_LEN] = '{
    '{1'b0, 3'd0, REQ_START,  5'd0,  1'b0, 3'd0, 20'd0},
    '{1'b0, 3'd0, REQ_FINISH, 5'd0,  1'b0, 3'd0, 20'd0},
    '{1'b0, 3'd0, REQ_MSG,    5'd0,  1'b0, 3'd0, 20'd0},
    '{1'b0, 3'd0, REQ_MSG,    5'd1,  1'b0, 3'd2, {5'd1, 5'd2, 5'd0, 5'd0}},
    '{1'b0, 3'd0, REQ_MSG,    5'd25, 1'b0, 3'd0, 20'd0},
    '{1'b0, 3'd0, REQ_MSG,    5'd31, 1'b1, 3'd4, {5'd21, 5'd24, 5'd21, 5'd24}},
    '{1'b0, 3'd0, REQ_MSG,    5'd9,  1'b1, 3'd2, {5'd7, 5'd24, 5'd0, 5'd0}},
    '{1'b0, 3'd0, REQ_MSG,    5'd0,  1'b0, 3'd0, 20'd0},
    '{1'b0, 3'd0, REQ_MSG,    5'd5,  1'b1, 3'd2, {5'd5, 5'd11, 5'd0, 5'd0}},
    '{1'b1, ADDR_MODE, REQ_START, 5'd0, 1'b0, 3'd0, 20'd0},
    '{1'b0, 3'd0, REQ_MSG,    5'd1,  1'b0, 3'd0, 20'd0},
    '{1'b0, 3'd0, REQ_MSG,    5'd2,  1'b0, 3'd2, {5'd0, 5'd1, 5'd0, 5'd0}},
    '{1'b1, ADDR_PAD,  REQ_START, 5'd25, 1'b0, 3'd0, 20'd0},
    '{1'b0, 3'd0, REQ_MSG,    5'd25, 1'b0, 3'd0, 20'd0},
    '{1'b0, 3'd0, REQ_MSG,    5'd25, 1'b1, 3'd4, {5'd24, 5'd24, 5'd24, 5'd24}},
    '{1'b1, ADDR_PAD,  REQ_START, 5'd0, 1'b0, 3'd0, 20'd0},
    '{1'b0, 3'd0, REQ_MSG,    5'd4,  1'b1, 3'd2, {5'd3, 5'd4, 5'd0, 5'd0}},
    '{1'b1, ADDR_PAD,  REQ_START, 5'd9, 1'b0, 3'd0, 20'd0},
    '{1'b1, ADDR_MODE, REQ_START, 5'd1, 1'b0, 3'd0, 20'd0},
    '{1'b0, 3'd0, REQ_START,  5'd0,  1'b0, 3'd0, 20'd0},
    '{1'b0, 3'd0, REQ_KEY,    5'd10, 1'b0, 3'd0, 20'd0},
    '{1'b0, 3'd0, REQ_KEY,    5'd9,  1'b0, 3'd0, 20'd0},
    '{1'b0, 3'd0, REQ_KEY,    5'd31, 1'b0, 3'd0, 20'd0},
    '{1'b0, 3'd0, REQ_KEY,    5'd10, 1'b0, 3'd0, 20'd0},
    '{1'b0, 3'd0, REQ_MSG,    5'd0,  1'b0, 3'd0, 20'd0},
    '{1'b0, 3'd0, REQ_MSG,    5'd10, 1'b0, 3'd0, 20'd0},
    '{1'b0, 3'd0, REQ_FINISH, 5'd0,  1'b0, 3'd0, 20'd0},
    '{1'b0, 3'd0, REQ_KEY,    5'd12, 1'b0, 3'd0, 20'd0},
    '{1'b0, 3'd0, REQ_MSG,    5'd7,  1'b0, 3'd0, 20'd0},
    '{1'b0, 3'd0, REQ_MSG,    5'd7,  1'b0, 3'd0, 20'd0},
    '{1'b0, 3'd0, REQ_MSG,    5'd8,  1'b1, 3'd0, 20'd0},
    '{1'b0, 3'd0, REQ_MSG,    5'd19, 1'b1, 3'd0, 20'd0}
  };

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'd0;   // [4:0] letter
  logic [1:0]  s_tuser = 2'd0;   // [1:0] req_type
  logic        s_tlast = 1'b0;   // message_end
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [7:0]  m_tdata;          // [4:0] out_letter
  logic        m_tlast;          // run_last
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = 3'd0;
  logic [31:0] pwdata = 32'd0;
  logic [31:0] prdata;
  logic        pready;

  letter_t     cipher_sq [25];
  letter_t     square_pos [26];
  logic [25:0] letter_taken;
  int          square_fill;
  letter_t     held_let;
  logic        held_ok;
  logic        enc_mode;
  letter_t     pad_reg;
  result_t     step_res [4];
  int          step_n;

  result_t     expected_out [$];
  int          mismatches = 0;
  int          items_sent = 0;
  int          snd_idle = 0;
  int          rcv_idle = 0;

  playfair_digraph_cipher u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #5 clk = ~clk;

  function automatic letter_t canon_letter(letter_t v);
    if (v > 5'd25) return 5'd25;
    if (v == 5'd9) return 5'd8;
    return v;
  endfunction

  task automatic add_expected(result_t r);
    expected_out.insert(expected_out.size(), r);
  endtask

  task automatic place_key(letter_t l);
    if (l >= 5'd26 || l == 5'd9 || letter_taken[l] || square_fill >= 25) return;
    cipher_sq[square_fill] = l;
    square_pos[l] = letter_t'(square_fill);
    letter_taken[l] = 1'b1;
    square_fill++;
  endtask

  task automatic encode_pair(letter_t a, letter_t b);
    int pa, pb, ar, ac, br, bc, sh;
    letter_t x, y;
    pa = int'(square_pos[a]) % 25;
    pb = int'(square_pos[b]) % 25;
    ar = pa / 5;
    ac = pa % 5;
    br = pb / 5;
    bc = pb % 5;
    sh = enc_mode ? 1 : 4;
    if (ar == br) begin
      x = cipher_sq[ar * 5 + (ac + sh) % 5];
      y = cipher_sq[br * 5 + (bc + sh) % 5];
    end else if (ac == bc) begin
      x = cipher_sq[((ar + sh) % 5) * 5 + ac];
      y = cipher_sq[((br + sh) % 5) * 5 + bc];
    end else begin
      x = cipher_sq[ar * 5 + bc];
      y = cipher_sq[br * 5 + ac];
    end
    step_res[step_n] = '{x, 1'b0};
    step_res[step_n + 1] = '{y, 1'b0};
    step_n += 2;
  endtask

  task automatic cipher_step(req_t req, letter_t ltr, logic last);
    letter_t l, p;
    step_n = 0;
    case (req)
      REQ_START: begin
        letter_taken = '0;
        square_fill = 0;
        held_ok = 1'b0;
      end
      REQ_KEY: begin
        place_key(ltr);
      end
      REQ_FINISH: begin
        for (int i = 0; i < 26; i++) place_key(letter_t'(i));
      end
      default: begin
        l = canon_letter(ltr);
        p = canon_letter(pad_reg);
        if (!held_ok) begin
          if (last) begin
            encode_pair(l, p);
          end else begin
            held_let = l;
            held_ok = 1'b1;
          end
        end else if (held_let == l) begin
          encode_pair(held_let, p);
          if (last) begin
            encode_pair(l, p);
            held_ok = 1'b0;
          end
        end else begin
          encode_pair(held_let, l);
          held_ok = 1'b0;
        end
        if (step_n > 0) step_res[step_n - 1].last = 1'b1;
      end
    endcase
  endtask

  task automatic send_req(req_t req, letter_t ltr, logic last, logic [2:0] nres, quad_t lets);
    while ($urandom_range(0, 99) < snd_idle) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= req;
    s_tdata  <= {3'b000, ltr};
    s_tlast  <= last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    items_sent++;
    cipher_step(req, ltr, last);
    if (nres != 3'd0) begin
      for (int k = 0; k < nres; k++) add_expected('{lets[k], k == nres - 1});
    end else begin
      for (int k = 0; k < step_n; k++) add_expected(step_res[k]);
    end
  endtask

  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (expected_out.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic reg_write(logic [2:0] addr, logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr == ADDR_MODE) enc_mode = val[0];
    else pad_reg = val[4:0];
  endtask

  task automatic random_traffic(int target);
    int kind, n;
    letter_t prev, cur;
    while (items_sent < target) begin
      kind = $urandom_range(0, 99);
      if (kind < 12) begin
        send_req(REQ_START, letter_t'($urandom_range(0, 31)),
                 1'($urandom_range(0, 1)), 3'd0, '0);
        n = $urandom_range(0, 14);
        for (int k = 0; k < n; k++) begin
          send_req(REQ_KEY, letter_t'($urandom_range(0, 31)),
                   1'($urandom_range(0, 1)), 3'd0, '0);
        end
        if ($urandom_range(0, 7) == 0) begin
          send_req(REQ_MSG, letter_t'($urandom_range(0, 25)), 1'b0, 3'd0, '0);
        end
        send_req(REQ_FINISH, letter_t'($urandom_range(0, 31)),
                 1'($urandom_range(0, 1)), 3'd0, '0);
      end else if (kind < 88) begin
        n = $urandom_range(1, 12);
        prev = letter_t'($urandom_range(0, 25));
        for (int k = 0; k < n; k++) begin
          if ($urandom_range(0, 3) == 0) cur = prev;
          else if ($urandom_range(0, 11) == 0) cur = letter_t'($urandom_range(26, 31));
          else cur = letter_t'($urandom_range(0, 25));
          send_req(REQ_MSG, cur, k == n - 1, 3'd0, '0);
          prev = cur;
        end
      end else begin
        n = $urandom_range(1, 4);
        for (int k = 0; k < n; k++) begin
          send_req(req_t'($urandom_range(0, 3)), letter_t'($urandom_range(0, 31)),
                   1'($urandom_range(0, 1)), 3'd0, '0);
        end
      end
      if ($urandom_range(0, 9) == 0) begin
        wait_idle();
        if ($urandom_range(0, 1) == 0) begin
          reg_write(ADDR_MODE, $urandom_range(0, 1));
        end else begin
          case ($urandom_range(0, 3))
            0: reg_write(ADDR_PAD, 32'd0);
            1: reg_write(ADDR_PAD, 32'd25);
            default: reg_write(ADDR_PAD, $urandom_range(0, 25));
          endcase
        end
      end
    end
  endtask

  task automatic note_mismatch(string what, result_t want, result_t got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%s: expected letter %0d last %0b, got letter %0d last %0b",
               what, want.letter, want.last, got.letter, got.last);
    end
  endtask

  always @(posedge clk) begin : out_check
    result_t want, got;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(0, 99) >= rcv_idle);
      if (m_tvalid && m_tready) begin
        got = '{m_tdata[4:0], m_tlast};
        if (expected_out.size() == 0) begin
          note_mismatch("unexpected result", '0, got);
        end else begin
          want = expected_out.pop_front();
          if (got !== want) note_mismatch("wrong result", want, got);
        end
      end
    end
  end

  initial begin
    for (int i = 0; i < 25; i++) cipher_sq[i] = '0;
    for (int i = 0; i < 26; i++) square_pos[i] = '0;
    letter_taken = '0;
    square_fill = 0;
    held_let = '0;
    held_ok = 1'b0;
    enc_mode = 1'b1;
    pad_reg = PAD_RESET;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    snd_idle = 29;
    rcv_idle = 47;
    foreach (SCRIPT[i]) begin
      if (SCRIPT[i].is_cfg) begin
        wait_idle();
        reg_write(SCRIPT[i].addr, {27'd0, SCRIPT[i].ltr});
      end else begin
        send_req(SCRIPT[i].req, SCRIPT[i].ltr, SCRIPT[i].last, SCRIPT[i].nres, SCRIPT[i].lets);
      end
    end
    random_traffic(140);

    snd_idle = 47;
    rcv_idle = 29;
    random_traffic(280);

    snd_idle = 0;
    rcv_idle = 0;
    random_traffic(410);

    wait_idle();
    if (mismatches == 0) begin
      $display("playfair_digraph_cipher_tb OK");
    end else begin
      $display("playfair_digraph_cipher_tb NOT OK");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("playfair_digraph_cipher_tb NOT OK");
    $finish;
  end

endmodule
